FILE: rtl/brdm_pkg.sv
`timescale 1ns / 1ps

package brdm_pkg;

   // Store geometry: main 64K plus four 64K RAM disk pages
   localparam int unsigned STORE_BYTES = 327680;
   localparam int unsigned PHYS_W      = 19;
   localparam int unsigned CPU_ADDR_W  = 16;

   // Bus commands
   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_CONTROL = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   // Control byte layout
   localparam int unsigned CTL_WIN_PAGE_LSB   = 0;
   localparam int unsigned CTL_STACK_PAGE_LSB = 2;
   localparam int unsigned CTL_STACK_EN_BIT   = 4;
   localparam int unsigned CTL_WIN_EN_LSB     = 5;

   // Window enable bits
   localparam int unsigned WIN_A000 = 0;
   localparam int unsigned WIN_8000 = 1;
   localparam int unsigned WIN_E000 = 2;

   typedef struct packed {
      logic [1:0]            command;
      logic [CPU_ADDR_W-1:0] address;
      logic [7:0]            data;
      logic                  stack_request;
   } req_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic [PHYS_W-1:0] physical_address;
   } rsp_type;

   typedef struct packed {
      logic       stack_redirect;
      logic [2:0] window_enables;
      logic [1:0] window_page;
      logic [1:0] stack_page;
   } map_cfg_type;

   // Extend a CPU address to the page address, then bank-interleave it.
   // A page field f selects page f+1, i.e. the top three bits become f+1.
   function automatic logic [PHYS_W-1:0] map_address(
      input logic [CPU_ADDR_W-1:0] addr,
      input logic                  stk,
      input map_cfg_type           cfg
   );
      logic [2:0]        page;
      logic [PHYS_W-1:0] ext;
      logic              in_a000;
      logic              in_8000;
      logic              in_e000;
      in_a000 = (addr >= 16'hA000) && (addr <= 16'hDFFF);
      in_8000 = (addr >= 16'h8000) && (addr <= 16'h9FFF);
      in_e000 = (addr >= 16'hE000);
      page    = 3'd0;
      if (cfg.stack_redirect && stk) begin
         page = {1'b0, cfg.stack_page} + 3'd1;
      end else if ((cfg.window_enables[WIN_A000] && in_a000) ||
                   (cfg.window_enables[WIN_8000] && in_8000) ||
                   (cfg.window_enables[WIN_E000] && in_e000)) begin
         page = {1'b0, cfg.window_page} + 3'd1;
      end
      ext = {page, addr};
      return {ext[18:15], ext[12:0], ext[14:13]};
   endfunction

endpackage

FILE: rtl/banked_ram_disk_mapper.sv
`timescale 1ns / 1ps

// A result strobes after the transfer on start passes the map stage and then the
// memory access stage. Throughput: one item per cycle while busy is low, set by the
// one store access that each item makes. Reset clears control and mapper state, then
// a clearing pass zeroes the 327680-byte store one byte a cycle, with busy high.
// The receiver cannot stall: each result is on rsp_payload for one cycle only.
module banked_ram_disk_mapper (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  brdm_pkg::req_type req_payload,
   output logic              rsp_valid,
   output brdm_pkg::rsp_type rsp_payload
);

   // Byte store
   logic [7:0] mem [brdm_pkg::STORE_BYTES];

   // Clearing pass
   logic                        clearing_ff;
   logic                        clearing_in;
   logic [brdm_pkg::PHYS_W-1:0] clr_addr_ff;
   logic [brdm_pkg::PHYS_W-1:0] clr_addr_in;

   // Mapper control
   brdm_pkg::map_cfg_type cfg_ff;
   brdm_pkg::map_cfg_type cfg_in;

   // Map stage
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic [1:0]                  s1_cmd_ff;
   logic [7:0]                  s1_data_ff;
   logic [brdm_pkg::PHYS_W-1:0] s1_phys_ff;

   // Access stage
   logic                        s2_valid_ff;
   logic [1:0]                  s2_cmd_ff;
   logic [brdm_pkg::PHYS_W-1:0] s2_phys_ff;
   logic [7:0]                  rd_data_ff;

   logic                        accept;
   logic                        mem_we;
   logic [brdm_pkg::PHYS_W-1:0] mem_waddr;
   logic [7:0]                  mem_wdata;
   logic                        s2_is_rw;

   assign busy   = clearing_ff;
   assign accept = start && !clearing_ff;

   // Clear sweep sequencing
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + brdm_pkg::PHYS_W'(1);
         if (clr_addr_ff == brdm_pkg::PHYS_W'(brdm_pkg::STORE_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Control byte decode on transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (accept && (req_payload.command == brdm_pkg::CMD_CONTROL)) begin
         cfg_in.stack_redirect = req_payload.data[brdm_pkg::CTL_STACK_EN_BIT];
         cfg_in.window_enables = req_payload.data[brdm_pkg::CTL_WIN_EN_LSB +: 3];
         cfg_in.window_page    = req_payload.data[brdm_pkg::CTL_WIN_PAGE_LSB +: 2];
         cfg_in.stack_page     = req_payload.data[brdm_pkg::CTL_STACK_PAGE_LSB +: 2];
      end
   end

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         cfg_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Map stage payload: mapping uses the control state before this transfer
   always_ff @(posedge clock) begin
      s1_cmd_ff  <= req_payload.command;
      s1_data_ff <= req_payload.data;
      s1_phys_ff <= brdm_pkg::map_address(req_payload.address,
                                          req_payload.stack_request, cfg_ff);
      s2_cmd_ff  <= s1_cmd_ff;
      s2_phys_ff <= s1_phys_ff;
   end

   // Write port shared by the clear sweep and CPU writes
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = s1_phys_ff;
      mem_wdata = s1_data_ff;
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (s1_valid_ff && (s1_cmd_ff == brdm_pkg::CMD_WRITE)) begin
         mem_we = 1'b1;
      end
   end

   // Store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[s1_phys_ff];
   end

   // Result
   assign s2_is_rw = (s2_cmd_ff == brdm_pkg::CMD_READ) ||
                     (s2_cmd_ff == brdm_pkg::CMD_WRITE);

   always_comb begin
      rsp_valid                    = s2_valid_ff;
      rsp_payload.read_data        = (s2_cmd_ff == brdm_pkg::CMD_READ) ? rd_data_ff : 8'd0;
      rsp_payload.physical_address = s2_is_rw ? s2_phys_ff : '0;
   end

endmodule

FILE: sim/banked_ram_disk_mapper_tb.sv
`timescale 1ns / 1ps

module banked_ram_disk_mapper_tb;

   localparam int unsigned NUM_ITEMS   = 1250;
   localparam int unsigned DRAIN_EVERY = 400;

   // Shadow of the mapper: control state, byte store and pending responses
   class ram_disk_shadow;
      brdm_pkg::map_cfg_type map_cfg;
      bit [7:0]              store_bytes [brdm_pkg::STORE_BYTES];
      brdm_pkg::rsp_type     pending_rsp[$];
      int unsigned           errors;

      function new();
         map_cfg = '0;
         errors  = 0;
      endfunction

      function int unsigned pending_count();
         return pending_rsp.size();
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         $display("ERROR @%0t: %s got %h want %h", $realtime, what, got, want);
         errors++;
      endtask

      // Page-extend a CPU address, then bank-interleave it
      function logic [brdm_pkg::PHYS_W-1:0] map_phys(
         input logic [brdm_pkg::CPU_ADDR_W-1:0] addr,
         input logic                            stk
      );
         logic [2:0]                  pg;
         logic [brdm_pkg::PHYS_W-1:0] ext;
         pg = 3'd0;
         if (map_cfg.stack_redirect && stk) begin
            pg = {1'b0, map_cfg.stack_page} + 3'd1;
         end else if (map_cfg.window_enables[brdm_pkg::WIN_A000] && addr >= 16'hA000 &&
                      addr <= 16'hDFFF) begin
            pg = {1'b0, map_cfg.window_page} + 3'd1;
         end else if (map_cfg.window_enables[brdm_pkg::WIN_8000] && addr >= 16'h8000 &&
                      addr <= 16'h9FFF) begin
            pg = {1'b0, map_cfg.window_page} + 3'd1;
         end else if (map_cfg.window_enables[brdm_pkg::WIN_E000] && addr >= 16'hE000) begin
            pg = {1'b0, map_cfg.window_page} + 3'd1;
         end
         ext = {3'b000, addr} + (brdm_pkg::PHYS_W'(pg) << 16);
         return (ext & 19'h78000) | ((ext << 2) & 19'h07FFC) | ((ext >> 13) & 19'h00003);
      endfunction

      // Accepted request: update shadow state and queue the response
      task note_access(input brdm_pkg::req_type r);
         brdm_pkg::rsp_type exp_rsp;
         logic [18:0]       phys;
         exp_rsp = '0;
         case (brdm_pkg::cmd_type'(r.command))
            brdm_pkg::CMD_CONTROL: begin
               map_cfg.stack_redirect = r.data[brdm_pkg::CTL_STACK_EN_BIT];
               map_cfg.window_enables = r.data[brdm_pkg::CTL_WIN_EN_LSB +: 3];
               map_cfg.window_page    = r.data[brdm_pkg::CTL_WIN_PAGE_LSB +: 2];
               map_cfg.stack_page     = r.data[brdm_pkg::CTL_STACK_PAGE_LSB +: 2];
            end
            brdm_pkg::CMD_READ: begin
               phys = map_phys(r.address, r.stack_request);
               exp_rsp.read_data        = store_bytes[phys];
               exp_rsp.physical_address = phys;
            end
            brdm_pkg::CMD_WRITE: begin
               phys = map_phys(r.address, r.stack_request);
               store_bytes[phys]        = r.data;
               exp_rsp.physical_address = phys;
            end
            default: ;
         endcase
         pending_rsp = {pending_rsp, exp_rsp};
      endtask

      // Response transfer: compare with the oldest pending response
      task check_response(input brdm_pkg::rsp_type got);
         brdm_pkg::rsp_type want;
         if (pending_rsp.size() == 0) begin
            report("unexpected response, addr/data", {5'b0, got}, 32'h0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.read_data !== want.read_data)
               report("read_data", 32'(got.read_data), 32'(want.read_data));
            if (got.physical_address !== want.physical_address)
               report("physical_address", 32'(got.physical_address),
                      32'(want.physical_address));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   brdm_pkg::req_type req_payload;
   logic              rsp_valid;
   brdm_pkg::rsp_type rsp_payload;

   ram_disk_shadow  shadow = new();
   logic [15:0]     hot_addr [16];
   logic [15:0]     edge_addr [10];

   banked_ram_disk_mapper u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         shadow.check_response(rsp_payload);
   end

   // Watchdog; covers the store clearing pass after reset
   initial begin
      #20_000_000;
      $display("banked_ram_disk_mapper: mismatch");
      $finish;
   end

   function automatic brdm_pkg::req_type mk(input brdm_pkg::cmd_type cmd,
                                            input logic [15:0] addr,
                                            input logic [7:0] data, input logic stk);
      brdm_pkg::req_type r;
      r.command       = cmd;
      r.address       = addr;
      r.data          = data;
      r.stack_request = stk;
      return r;
   endfunction

   // Random request; addresses favor a small hot set and window edges so reads
   // land on bytes written earlier
   function automatic brdm_pkg::req_type random_item();
      brdm_pkg::req_type r;
      int unsigned       sel;
      sel = $urandom_range(0, 99);
      if (sel < 42)      r.command = brdm_pkg::CMD_READ;
      else if (sel < 84) r.command = brdm_pkg::CMD_WRITE;
      else if (sel < 95) r.command = brdm_pkg::CMD_CONTROL;
      else               r.command = brdm_pkg::CMD_NONE;
      sel = $urandom_range(0, 9);
      if (sel < 5)      r.address = hot_addr[$urandom_range(0, 15)];
      else if (sel < 7) r.address = edge_addr[$urandom_range(0, 9)];
      else              r.address = 16'($urandom);
      r.data          = 8'($urandom);
      r.stack_request = 1'($urandom);
      if ($urandom_range(0, 31) == 0)
         hot_addr[$urandom_range(0, 15)] = 16'($urandom);
      return r;
   endfunction

   // One transfer: hold start until the block is not busy
   task send_item(input brdm_pkg::req_type r);
      logic taken;
      start       = 1'b1;
      req_payload = r;
      taken       = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      shadow.note_access(r);
      @(negedge clock);
   endtask

   task idle_cycles(input int unsigned n);
      if (n != 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task drain();
      start = 1'b0;
      while (shadow.pending_count() != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned sent;
      int unsigned burst;
      int unsigned next_drain;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      edge_addr   = '{16'h0000, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000,
                      16'hDFFF, 16'hE000, 16'hFFFF, 16'h5555, 16'hAAAA};
      foreach (hot_addr[i]) hot_addr[i] = 16'($urandom);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: cleared store, ignored stack flag at reset, unused command,
      // stack priority, each window and its edges, top page
      send_item(mk(brdm_pkg::CMD_READ,    16'h0000, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_WRITE,   16'hFFFF, 8'hFF, 1'b1));
      send_item(mk(brdm_pkg::CMD_READ,    16'hFFFF, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_NONE,    16'hFFFF, 8'hFF, 1'b1));
      send_item(mk(brdm_pkg::CMD_CONTROL, 16'h0000, 8'hF0, 1'b0));
      send_item(mk(brdm_pkg::CMD_WRITE,   16'h8000, 8'h5A, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'h8000, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_CONTROL, 16'hFFFF, 8'hFF, 1'b1));
      send_item(mk(brdm_pkg::CMD_WRITE,   16'hFFFF, 8'hA5, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'hFFFF, 8'h00, 1'b1));
      send_item(mk(brdm_pkg::CMD_CONTROL, 16'h0000, 8'hFC, 1'b0));
      send_item(mk(brdm_pkg::CMD_WRITE,   16'hA000, 8'h11, 1'b1));
      send_item(mk(brdm_pkg::CMD_WRITE,   16'hA000, 8'h22, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'hA000, 8'h00, 1'b1));
      send_item(mk(brdm_pkg::CMD_READ,    16'h9FFF, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'hDFFF, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'hE000, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'h7FFF, 8'h00, 1'b1));
      send_item(mk(brdm_pkg::CMD_CONTROL, 16'h0000, 8'h20, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'h9FFF, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'hA000, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_CONTROL, 16'h0000, 8'h00, 1'b0));
      send_item(mk(brdm_pkg::CMD_READ,    16'hA000, 8'h00, 1'b0));
      drain();

      // Random bursts with gaps; full drain now and then
      sent       = 0;
      next_drain = DRAIN_EVERY;
      while (sent < NUM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int unsigned i = 0; i < burst && sent < NUM_ITEMS; i++) begin
            send_item(random_item());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            idle_cycles($urandom_range(1, 6));
         if (sent >= next_drain) begin
            drain();
            next_drain += DRAIN_EVERY;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (shadow.pending_count() != 0)
         shadow.report("responses missing, count", shadow.pending_count(), 32'h0);
      if (shadow.errors == 0)
         $display("banked_ram_disk_mapper: match");
      else
         $display("banked_ram_disk_mapper: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
rtl/brdm_pkg.sv
rtl/banked_ram_disk_mapper.sv
sim/banked_ram_disk_mapper_tb.sv
